FILE: design/sealed_record_hex_parser_top_defines.svh
// Assertion macros shared by the sealed record hex parser RTL.
`ifndef SEALED_RECORD_HEX_PARSER_TOP_DEFINES_SVH
`define SEALED_RECORD_HEX_PARSER_TOP_DEFINES_SVH

// Flag any clock edge at which the condition holds.
`define SRHP_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// Flag a consequent that fails in the cycle after its antecedent.
`define SRHP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/srhp_pkg.sv
// Types, codes and helpers of the sealed record hex parser.
package srhp_pkg;

   localparam int MAX_CIPHER_BYTES = 64;
   localparam logic [7:0] MAX_CIPHER_DIGITS = 8'(2 * MAX_CIPHER_BYTES);
   localparam logic [7:0] NONCE_DIGITS = 8'd24;
   localparam logic [7:0] TAG_DIGITS = 8'd32;
   localparam logic [7:0] COUNT_MAX = 8'd255;
   localparam logic [7:0] CHAR_COLON = 8'h3a;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Parser phases
   localparam logic [2:0] PH_PREFIX = 3'd0;
   localparam logic [2:0] PH_NONCE = 3'd1;
   localparam logic [2:0] PH_TAG = 3'd2;
   localparam logic [2:0] PH_CIPHER = 3'd3;
   localparam logic [2:0] PH_TAG_LENBAD = 3'd4;
   localparam logic [2:0] PH_CIPHER_LENBAD = 3'd5;

   // Result kinds
   localparam logic [1:0] KIND_NONCE = 2'd0;
   localparam logic [1:0] KIND_TAG = 2'd1;
   localparam logic [1:0] KIND_CIPHER = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   // Record status codes
   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_VERSION = 3'd1;
   localparam logic [2:0] ST_SEPARATOR = 3'd2;
   localparam logic [2:0] ST_LENGTH = 3'd3;
   localparam logic [2:0] ST_HEAD_HEX = 3'd4;
   localparam logic [2:0] ST_CIPHER_SIZE = 3'd5;
   localparam logic [2:0] ST_CIPHER_HEX = 3'd6;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] byte_value;
      logic [2:0] status;
      logic       record_end;
   } result_type;

   // Up to two results from one character, first one first.
   typedef struct packed {
      logic [1:0] num;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } nibble_type;

   function automatic nibble_type hex_nibble(input logic [7:0] c);
      nibble_type n;
      n.ok = 1'b1;
      n.value = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         n.value = c[3:0];
      end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         n.value = c[3:0] + 4'd9;
      end else begin
         n.ok = 1'b0;
      end
      return n;
   endfunction

   function automatic logic [7:0] prefix_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0: c = 8'h76;
         2'd1: c = 8'h31;
         2'd2: c = CHAR_COLON;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

FILE: design/srhp_parse.sv
// Record state and per-character decode: produces up to two results per character.
module srhp_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [7:0]          char_value,
   input  logic                last,
   output srhp_pkg::push_type  push
);

   logic [2:0] phase_ff, phase_in;
   logic [7:0] count_ff, count_in;
   logic [3:0] high_ff, high_in;
   logic       pbad_ff, pbad_in;
   logic       hbad_ff, hbad_in;
   logic       cbad_ff, cbad_in;
   logic       ended_ff, ended_in;

   srhp_pkg::nibble_type nib;
   logic       byte_valid;
   logic [1:0] byte_kind;
   logic [7:0] byte_val;
   logic       status_valid;
   logic [2:0] status_code;
   srhp_pkg::result_type byte_item;
   srhp_pkg::result_type status_item;

   assign nib = srhp_pkg::hex_nibble(char_value);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      high_in = high_ff;
      pbad_in = pbad_ff;
      hbad_in = hbad_ff;
      cbad_in = cbad_ff;
      ended_in = ended_ff;
      byte_valid = 1'b0;
      byte_kind = srhp_pkg::KIND_NONCE;
      byte_val = {high_ff, nib.value};
      status_valid = 1'b0;
      status_code = srhp_pkg::ST_OK;

      if (fire && !ended_ff) begin
         if (char_value == 8'h00) begin
            ended_in = 1'b1;
         end else if (phase_ff == srhp_pkg::PH_PREFIX) begin
            if (!pbad_ff) begin
               if (count_ff < 8'd3 && char_value == srhp_pkg::prefix_char(count_ff[1:0])) begin
                  if (count_ff == 8'd2) begin
                     phase_in = srhp_pkg::PH_NONCE;
                     count_in = 8'd0;
                     high_in = 4'd0;
                  end else begin
                     count_in = count_ff + 8'd1;
                  end
               end else begin
                  pbad_in = 1'b1;
               end
            end
         end else if (char_value == srhp_pkg::CHAR_COLON && phase_ff == srhp_pkg::PH_NONCE) begin
            phase_in = (count_ff == srhp_pkg::NONCE_DIGITS) ? srhp_pkg::PH_TAG
                                                            : srhp_pkg::PH_TAG_LENBAD;
            count_in = 8'd0;
            high_in = 4'd0;
         end else if (char_value == srhp_pkg::CHAR_COLON &&
                      (phase_ff == srhp_pkg::PH_TAG || phase_ff == srhp_pkg::PH_TAG_LENBAD)) begin
            phase_in = (phase_ff == srhp_pkg::PH_TAG && count_ff == srhp_pkg::TAG_DIGITS)
                       ? srhp_pkg::PH_CIPHER : srhp_pkg::PH_CIPHER_LENBAD;
            count_in = 8'd0;
            high_in = 4'd0;
         end else if (phase_ff <= srhp_pkg::PH_CIPHER_LENBAD) begin
            if (phase_ff == srhp_pkg::PH_NONCE) begin
               byte_kind = srhp_pkg::KIND_NONCE;
            end else if (phase_ff == srhp_pkg::PH_TAG || phase_ff == srhp_pkg::PH_TAG_LENBAD) begin
               byte_kind = srhp_pkg::KIND_TAG;
            end else begin
               byte_kind = srhp_pkg::KIND_CIPHER;
            end
            if (!nib.ok) begin
               if (byte_kind == srhp_pkg::KIND_CIPHER) begin
                  cbad_in = 1'b1;
               end else begin
                  hbad_in = 1'b1;
               end
            end
            // A saturated field stops emitting bytes
            if (count_ff != srhp_pkg::COUNT_MAX) begin
               if (!count_ff[0]) begin
                  high_in = nib.value;
               end else begin
                  byte_valid = 1'b1;
               end
               count_in = count_ff + 8'd1;
            end
         end
      end

      if (fire && last) begin
         status_valid = 1'b1;
         if (phase_in == srhp_pkg::PH_PREFIX || pbad_in) begin
            status_code = srhp_pkg::ST_VERSION;
         end else if (phase_in == srhp_pkg::PH_NONCE || phase_in == srhp_pkg::PH_TAG ||
                      phase_in == srhp_pkg::PH_TAG_LENBAD) begin
            status_code = srhp_pkg::ST_SEPARATOR;
         end else if (phase_in != srhp_pkg::PH_CIPHER || count_in == 8'd0) begin
            status_code = srhp_pkg::ST_LENGTH;
         end else if (hbad_in) begin
            status_code = srhp_pkg::ST_HEAD_HEX;
         end else if (count_in[0] || count_in > srhp_pkg::MAX_CIPHER_DIGITS) begin
            status_code = srhp_pkg::ST_CIPHER_SIZE;
         end else if (cbad_in) begin
            status_code = srhp_pkg::ST_CIPHER_HEX;
         end else begin
            status_code = srhp_pkg::ST_OK;
         end
         // Re-arm for the next record
         phase_in = srhp_pkg::PH_PREFIX;
         count_in = 8'd0;
         high_in = 4'd0;
         pbad_in = 1'b0;
         hbad_in = 1'b0;
         cbad_in = 1'b0;
         ended_in = 1'b0;
      end
   end

   always_comb begin
      byte_item.kind = byte_kind;
      byte_item.byte_value = byte_val;
      byte_item.status = srhp_pkg::ST_OK;
      byte_item.record_end = 1'b0;
      status_item.kind = srhp_pkg::KIND_STATUS;
      status_item.byte_value = 8'd0;
      status_item.status = status_code;
      status_item.record_end = 1'b1;
      push.num = 2'({1'b0, byte_valid} + {1'b0, status_valid});
      push.first = byte_valid ? byte_item : status_item;
      push.second = status_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= srhp_pkg::PH_PREFIX;
         count_ff <= 8'd0;
         high_ff <= 4'd0;
         pbad_ff <= 1'b0;
         hbad_ff <= 1'b0;
         cbad_ff <= 1'b0;
         ended_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         high_ff <= high_in;
         pbad_ff <= pbad_in;
         hbad_ff <= hbad_in;
         cbad_ff <= cbad_in;
         ended_ff <= ended_in;
      end
   end

endmodule

FILE: design/srhp_result_fifo.sv
// Small result queue that takes up to two results per cycle and hands out one while the reader is ready.
module srhp_result_fifo (
   input  logic                                  clock,
   input  logic                                  reset,
   input  srhp_pkg::push_type                    push,
   output logic                                  room_for_two,
   output logic [srhp_pkg::FIFO_CNT_W-1:0]       fill,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output srhp_pkg::result_type                  out_item
);

   srhp_pkg::result_type entry_ff [srhp_pkg::FIFO_DEPTH];
   logic [srhp_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [srhp_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [srhp_pkg::FIFO_CNT_W-1:0] count_ff, count_in;
   logic                            pop;

   assign out_valid = (count_ff != '0);
   assign out_item = entry_ff[rd_ptr_ff];
   assign pop = out_valid && out_ready;
   assign fill = count_ff;
   assign room_for_two = (count_ff <= srhp_pkg::FIFO_CNT_W'(srhp_pkg::FIFO_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + srhp_pkg::FIFO_PTR_W'(push.num);
   assign rd_ptr_in = rd_ptr_ff + srhp_pkg::FIFO_PTR_W'(pop);
   assign count_in = count_ff + srhp_pkg::FIFO_CNT_W'(push.num)
                     - srhp_pkg::FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.num == 2'd2) begin
         entry_ff[wr_ptr_ff + srhp_pkg::FIFO_PTR_W'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: design/sealed_record_hex_parser_top.sv
// Flow: a transferred character is registered, then decoded once the result queue has room for two
// results; its results enter the queue at the edge that ends the decode and raise rsp_tvalid.
// Throughput: one character per cycle; the input holds while the four-entry result queue has
// fewer than two free entries, and a last character that also completes a byte yields two
// results, handed out in order, the byte first.
// Reset: synchronous, active high; clears the record state and empties the queue.
`include "sealed_record_hex_parser_top_defines.svh"

module sealed_record_hex_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] char_in
   input  logic        req_tlast,    // last_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [7:0] byte_value, [10:8] status, [15:11] zero
   output logic [1:0]  rsp_tuser,    // [1:0] kind
   output logic        rsp_tlast     // record_end
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] char_ff;
   logic       last_ff;
   logic       advance;
   logic       room_for_two;
   logic [srhp_pkg::FIFO_CNT_W-1:0] fill;
   srhp_pkg::push_type   push;
   srhp_pkg::result_type out_item;

   assign advance = in_valid_ff && room_for_two;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Hold the payload until the transfer lands
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         char_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   srhp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .char_value (char_ff),
      .last       (last_ff),
      .push       (push)
   );

   srhp_result_fifo u_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .room_for_two (room_for_two),
      .fill         (fill),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_item     (out_item)
   );

   assign rsp_tdata = {5'd0, out_item.status, out_item.byte_value};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.record_end;

   `SRHP_ASSERT_NEVER(a_fifo_bound, clock, reset,
      fill > srhp_pkg::FIFO_CNT_W'(srhp_pkg::FIFO_DEPTH), "result queue overflow")
   `SRHP_ASSERT_NEVER(a_status_shape, clock, reset,
      rsp_tvalid && (rsp_tuser == srhp_pkg::KIND_STATUS) != rsp_tlast,
      "record end does not match status kind")
   `SRHP_ASSERT_NEXT(a_stalled_char_kept, clock, reset, in_valid_ff && !advance,
      in_valid_ff, "stalled character dropped")

endmodule
